/* sv/sorted_priority_queue_unit_assert.svh */
// assertion macros for the sorted priority queue checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPQ_ASSERT_SAME(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("spq check failed");

// condition implies consequence in the next cycle
`define SPQ_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("spq check failed");

`endif

/* sv/spq_pkg.sv */
// shared types, constants and helpers of the sorted priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0]  key;
        logic [31:0] contact;
        logic [15:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        t_entry            data;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    // keeps the low bits of a rank
    function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] rank);
        logic [CNT_W+POS_W-1:0] w;
        w = {{POS_W{1'b0}}, rank};
        return w[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/spq_in_if.sv */
// request channel of the sorted priority queue
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::KIND_W-1:0] kind;
    logic [7:0]                key_age;
    logic [31:0]               contact;
    logic [15:0]               tag;

    modport source (output valid, output kind, output key_age, output contact,
                    output tag, input ready);
    modport sink   (input valid, input kind, input key_age, input contact,
                    input tag, output ready);
endinterface

`default_nettype wire

/* sv/spq_out_if.sv */
// result channel of the sorted priority queue
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface spq_out_if;
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::POS_W-1:0]  position;
    logic [7:0]                 out_age;
    logic [31:0]                out_contact;
    logic [15:0]                out_tag;
    logic                       last;

    modport source (output valid, output status, output position, output out_age,
                    output out_contact, output out_tag, output last, input ready);
    modport sink   (input valid, input status, input position, input out_age,
                    input out_contact, input out_tag, input last, output ready);
endinterface

`default_nettype wire

/* sv/spq_ram.sv */
// simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/spq_seq.sv */
// sequencer: walks the entry ram for insert, pop and list
// depends on spq_pkg and spq_ram
`timescale 1ns / 1ps
`default_nettype none

module spq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [spq_pkg::KIND_W-1:0]  i_kind,
    input  spq_pkg::t_entry             i_entry,
    input  logic                        i_out_free,
    output logic                        o_idle,
    output spq_pkg::t_push              o_push
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DISPATCH = 11'b00000000010,
        S_INS_RD   = 11'b00000000100,
        S_INS_WR   = 11'b00000001000,
        S_INS_HEAD = 11'b00000010000,
        S_POP_RD   = 11'b00000100000,
        S_POP_WR   = 11'b00001000000,
        S_LIST_RD  = 11'b00010000000,
        S_LIST_OUT = 11'b00100000000,
        S_RESULT   = 11'b01000000000,
        S_SPARE    = 11'b10000000000
    } t_state;

    t_state                        r_state, n_state;
    logic [spq_pkg::CNT_W-1:0]     r_count, n_count;
    logic [spq_pkg::ADDR_W-1:0]    r_idx, n_idx;
    logic [spq_pkg::STAT_W-1:0]    r_status, n_status;
    spq_pkg::t_entry               r_head, n_head;
    logic [spq_pkg::KIND_W-1:0]    r_kind;
    spq_pkg::t_entry               r_entry;

    logic                          w_we, w_re;
    logic [spq_pkg::ADDR_W-1:0]    w_waddr;
    spq_pkg::t_entry               w_wdata;
    logic [spq_pkg::ENTRY_W-1:0]   w_rdata_raw;
    spq_pkg::t_entry               w_rdata;
    logic [spq_pkg::ADDR_W-1:0]    w_idx_p1, w_idx_m1;
    logic [spq_pkg::CNT_W-1:0]     w_rank;
    logic                          w_at_tail;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata   = spq_pkg::t_entry'(w_rdata_raw);
    assign w_idx_p1  = spq_pkg::ADDR_W'(r_idx + 1'b1);
    assign w_idx_m1  = spq_pkg::ADDR_W'(r_idx - 1'b1);
    assign w_rank    = spq_pkg::CNT_W'(r_idx) + 1'b1;
    assign w_at_tail = (w_rank == r_count);
    assign o_idle    = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        n_head   = r_head;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_waddr  = w_idx_p1;
        w_wdata  = r_entry;
        o_push   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_head   = '0;
                n_status = spq_pkg::STATUS_OK;
                n_idx    = '0;
                case (r_kind)
                    spq_pkg::KIND_INSERT: begin
                        if (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                            n_status = spq_pkg::STATUS_FULL;
                            n_state  = S_RESULT;
                        end else if (r_count == '0) begin
                            w_we    = 1'b1;
                            w_waddr = '0;
                            n_count = r_count + 1'b1;
                            n_state = S_RESULT;
                        end else begin
                            n_idx   = spq_pkg::ADDR_W'(r_count - 1'b1);
                            n_state = S_INS_RD;
                        end
                    end
                    spq_pkg::KIND_POP: begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::STATUS_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    spq_pkg::KIND_LIST: begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::STATUS_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_LIST_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_RD: begin
                w_re    = 1'b1;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                w_we = 1'b1;
                if (w_rdata.key > r_entry.key) begin
                    n_count = r_count + 1'b1;
                    n_state = S_RESULT;
                end else begin
                    w_wdata = w_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        n_idx   = w_idx_m1;
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_HEAD: begin
                w_we    = 1'b1;
                w_waddr = '0;
                n_count = r_count + 1'b1;
                n_state = S_RESULT;
            end
            S_POP_RD: begin
                w_re    = 1'b1;
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                // shift each later entry down by one
                w_waddr = w_idx_m1;
                w_wdata = w_rdata;
                if (r_idx == '0) begin
                    n_head = w_rdata;
                end else begin
                    w_we = 1'b1;
                end
                if (w_at_tail) begin
                    n_count = r_count - 1'b1;
                    n_state = S_RESULT;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = S_POP_RD;
                end
            end
            S_LIST_RD: begin
                w_re    = 1'b1;
                n_state = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (i_out_free) begin
                    o_push.valid        = 1'b1;
                    o_push.res.status   = spq_pkg::STATUS_OK;
                    o_push.res.position = spq_pkg::to_pos(w_rank);
                    o_push.res.data     = w_rdata;
                    o_push.res.last     = w_at_tail;
                    if (w_at_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = w_idx_p1;
                        n_state = S_LIST_RD;
                    end
                end
            end
            S_RESULT: begin
                if (i_out_free) begin
                    o_push.valid      = 1'b1;
                    o_push.res.status = r_status;
                    o_push.res.data   = r_head;
                    o_push.res.last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_head   <= n_head;
        if (i_accept && o_idle) begin
            r_kind  <= i_kind;
            r_entry <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/sorted_priority_queue_unit.sv */
// sorted priority queue: one request in flight, entries in a 16-deep ram
// insert shifts each lower-or-equal entry toward the tail; insert into a full or empty queue needs no walk
// pop takes the head and shifts every later entry down; list reads each entry in order; empty gives empty
// output stalls hold the list walk and the result; requests are taken only when idle, throughput set by the ram walk
// synchronous active-low reset empties the queue and clears the output valid flag;
// ram contents are not cleared, only the first occupancy entries are ever read
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_req,
    spq_out_if.source o_rsp
);

    logic             w_idle;
    logic             w_accept;
    logic             w_out_free;
    spq_pkg::t_entry  w_entry;
    spq_pkg::t_push   w_push;
    logic             r_out_valid, n_out_valid;
    spq_pkg::t_result r_out_res;

    assign w_entry.key     = i_req.key_age;
    assign w_entry.contact = i_req.contact;
    assign w_entry.tag     = i_req.tag;
    assign i_req.ready     = w_idle;
    assign w_accept        = i_req.valid & w_idle;

    spq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_kind     (i_req.kind),
        .i_entry    (w_entry),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_push     (w_push)
    );

    // output word register
    assign w_out_free  = ~r_out_valid | o_rsp.ready;
    assign n_out_valid = w_push.valid | (r_out_valid & ~o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out_res <= w_push.res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_res.status;
    assign o_rsp.position    = r_out_res.position;
    assign o_rsp.out_age     = r_out_res.data.key;
    assign o_rsp.out_contact = r_out_res.data.contact;
    assign o_rsp.out_tag     = r_out_res.data.tag;
    assign o_rsp.last        = r_out_res.last;

endmodule

`default_nettype wire

/* sv/spq_chk.sv */
// port-level checker for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_unit_assert.svh"

module spq_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [spq_pkg::STAT_W-1:0] i_out_status,
    input logic [spq_pkg::POS_W-1:0]  i_out_position,
    input logic                       i_out_last
);

    `SPQ_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid)
    `SPQ_ASSERT_NEXT(a_rsp_stable, i_out_valid && !i_out_ready, $stable(i_out_status) && $stable(i_out_position) && $stable(i_out_last))
    `SPQ_ASSERT_NEXT(a_req_busy, i_in_valid && i_in_ready, !i_in_ready)
    `SPQ_ASSERT_SAME(a_list_busy, i_out_valid && i_out_ready && !i_out_last, !i_in_ready)

endmodule

bind sorted_priority_queue_unit spq_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_status   (o_rsp.status),
    .i_out_position (o_rsp.position),
    .i_out_last     (o_rsp.last)
);

`default_nettype wire

/* verif/testbench.sv */
// self-checking bench for sorted_priority_queue_unit: a directed pass, then a random regression
// a scoreboard class tracks the expected queue contents and result words
// depends on spq_pkg, spq_in_if, spq_out_if and the unit itself
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 286;
    localparam int MODE_FILL    = 0;
    localparam int MODE_DRAIN   = 1;
    localparam int MODE_MIXED   = 2;

    class queue_scoreboard;
        t_entry  ranked[$];
        t_result awaited[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, t_entry item);
            t_result r;
            int      at;
            r = '0;
            r.last = 1'b1;
            case (kind)
                KIND_INSERT: begin
                    if (ranked.size() >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        at = 0;
                        while (at < ranked.size() && ranked[at].key > item.key) at++;
                        ranked.insert(at, item);
                    end
                    awaited.push_back(r);
                end
                KIND_POP: begin
                    if (ranked.size() == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        r.data = ranked.pop_front();
                    end
                    awaited.push_back(r);
                end
                KIND_LIST: begin
                    if (ranked.size() == 0) begin
                        r.status = STATUS_EMPTY;
                        awaited.push_back(r);
                    end else begin
                        for (int i = 0; i < ranked.size(); i++) begin
                            r.position = POS_W'(i + 1);
                            r.data = ranked[i];
                            r.last = (i == ranked.size() - 1);
                            awaited.push_back(r);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (awaited.size() == 0) begin
                if (errors < 10)
                    $display("%0t unexpected word: st=%0d pos=%0d age=%0d ct=%h tag=%h last=%b",
                             $time, got.status, got.position, got.data.key,
                             got.data.contact, got.data.tag, got.last);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status || got.position !== exp.position ||
                got.data.key !== exp.data.key || got.data.contact !== exp.data.contact ||
                got.data.tag !== exp.data.tag || got.last !== exp.last) begin
                if (errors < 10) begin
                    $display("%0t mismatch exp: st=%0d pos=%0d age=%0d ct=%h tag=%h last=%b",
                             $time, exp.status, exp.position, exp.data.key,
                             exp.data.contact, exp.data.tag, exp.last);
                    $display("%0t mismatch got: st=%0d pos=%0d age=%0d ct=%h tag=%h last=%b",
                             $time, got.status, got.position, got.data.key,
                             got.data.contact, got.data.tag, got.last);
                end
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   burst_left = 0;

    queue_scoreboard sb = new();

    spq_in_if  req_if();
    spq_out_if rsp_if();

    sorted_priority_queue_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // request acceptance
    always @(posedge clk) begin : req_monitor
        t_entry item;
        if (rst_n && req_if.valid && req_if.ready) begin
            item.key = req_if.key_age;
            item.contact = req_if.contact;
            item.tag = req_if.tag;
            sb.note_request(req_if.kind, item);
        end
    end

    // result acceptance
    always @(posedge clk) begin : rsp_monitor
        t_result got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status = rsp_if.status;
            got.position = rsp_if.position;
            got.data.key = rsp_if.out_age;
            got.data.contact = rsp_if.out_contact;
            got.data.tag = rsp_if.out_tag;
            got.last = rsp_if.last;
            sb.check_result(got);
        end
    end

    // receiver stall pattern, cycling through four phases of different character
    initial begin : rsp_throttle
        int   hold;
        int   phase;
        logic level;
        hold = 0;
        level = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            phase = (cycle_count / 256) % 4;
            if (hold == 0) begin
                level = ~level;
                case (phase)
                    0: begin
                        level = 1'b1;
                        hold = 16;
                    end
                    1: hold = $urandom_range(1, 3);
                    2: hold = level ? $urandom_range(1, 8) : $urandom_range(4, 12);
                    default: hold = level ? $urandom_range(10, 30) : 1;
                endcase
            end
            hold--;
            rsp_if.ready <= level;
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [7:0] key,
                             input logic [31:0] contact, input logic [15:0] tag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.kind <= kind;
        req_if.key_age <= key;
        req_if.contact <= contact;
        req_if.tag <= tag;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic wait_queue_settled();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (sb.awaited.size() != 0);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(int mode);
        int roll;
        int ins_w;
        int pop_w;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                ins_w = 70;
                pop_w = 10;
            end
            MODE_DRAIN: begin
                ins_w = 15;
                pop_w = 60;
            end
            default: begin
                ins_w = 45;
                pop_w = 35;
            end
        endcase
        if (roll < ins_w) return KIND_INSERT;
        if (roll < ins_w + pop_w) return KIND_POP;
        if (roll < 96) return KIND_LIST;
        return KIND_UNUSED;
    endfunction

    function automatic logic [7:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 8'($urandom_range(0, 255));
        if (roll < 85) return 8'($urandom_range(120, 123));
        if (roll < 92) return 8'h00;
        return 8'hff;
    endfunction

    initial begin
        int               sent;
        int               mode;
        int               phase_len;
        logic [KIND_W-1:0] kind;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.kind <= KIND_INSERT;
        req_if.key_age <= '0;
        req_if.contact <= '0;
        req_if.tag <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue cases and the ignored kind
        send_word(KIND_POP, 8'h00, 32'h0, 16'h0);
        send_word(KIND_LIST, 8'hff, 32'hffff_ffff, 16'hffff);
        send_word(KIND_UNUSED, 8'h5a, 32'h1234_5678, 16'habcd);
        // extremes and equal keys
        send_word(KIND_INSERT, 8'hff, 32'hffff_ffff, 16'hffff);
        send_word(KIND_INSERT, 8'h00, 32'h0000_0000, 16'h0000);
        send_word(KIND_INSERT, 8'd100, 32'haaaa_5555, 16'h0001);
        send_word(KIND_INSERT, 8'd100, 32'h5555_aaaa, 16'h0002);
        send_word(KIND_LIST, 8'h00, 32'h0, 16'h0);
        send_word(KIND_POP, 8'h00, 32'h0, 16'h0);
        // fill up, then insert into a full queue
        for (int i = 0; i < 13; i++)
            send_word(KIND_INSERT, pick_key(), $urandom(), 16'($urandom_range(0, 65535)));
        send_word(KIND_INSERT, 8'd200, 32'hdead_beef, 16'h7777);
        send_word(KIND_LIST, 8'h00, 32'h0, 16'h0);
        wait_queue_settled();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            phase_len = $urandom_range(15, 40);
            if ($urandom_range(0, 2) == 0) wait_queue_settled();
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                kind = pick_kind(mode);
                send_word(kind, pick_key(), $urandom(), 16'($urandom_range(0, 65535)));
                if (kind != KIND_UNUSED) sent++;
            end
        end

        wait_queue_settled();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
